FILE: sv/sct_pkg.sv
// Shared types, codes and character classes for the source character tokenizer.
// No dependencies; imported by every module of the block.
package sct_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_QUOTE      = 8'h22;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_STRING = 2'd2,
        MODE_IDENT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_STRING   = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_OPERATOR = 3'd3,
        KIND_DELIM    = 3'd4,
        KIND_UNDEF    = 3'd5,
        KIND_END      = 3'd6
    } kind_t;

    // One classified byte: first token, and optionally a second that is
    // always the byte's own token (its value is the byte code).
    typedef struct packed {
        logic        two;
        kind_t       kind0;
        logic [63:0] value0;
        kind_t       kind1;
        logic [7:0]  char1;
    } sct_entry_t;

    typedef struct packed {
        logic second_pending;
    } sct_back_status_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha_us(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CHAR_UNDERSCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == 8'h3B) || (c == 8'h2C) || (c == 8'h28) || (c == 8'h29);
    endfunction

endpackage

FILE: sv/sct_front.sv
// Front end: scan mode and accumulator, byte classification into queue entries.
// Depends on sct_pkg.
module sct_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [7:0]         in_char,
    input  logic               push_ready,
    output logic               in_ready,
    output logic               push_valid,
    output sct_pkg::sct_entry_t push_entry
);
    import sct_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [63:0] acc_reg, acc_next;

    logic        accept;
    logic [63:0] acc_times10;
    logic [63:0] acc_shift8;
    logic [63:0] digit_ext;

    // idle-mode classification of the current byte
    logic        idle_emit;
    kind_t       idle_kind;
    mode_t       idle_mode;
    logic [63:0] idle_acc;

    // token pending from the current mode, closed by this byte
    logic        pend_emit;
    kind_t       pend_kind;
    logic        use_idle;

    assign in_ready    = push_ready;
    assign accept      = in_valid && push_ready;
    assign acc_times10 = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
    assign digit_ext   = {60'd0, in_char[3:0] - 4'd0};
    assign acc_shift8  = {acc_reg[55:0], in_char};

    always_comb begin
        idle_emit = 1'b0;
        idle_kind = KIND_UNDEF;
        idle_mode = MODE_IDLE;
        idle_acc  = acc_reg;
        priority if (in_char == CHAR_NUL) begin
            idle_emit = 1'b1;
            idle_kind = KIND_END;
            idle_acc  = 64'd0;
        end else if (is_space(in_char)) begin
            idle_emit = 1'b0;
        end else if (is_digit(in_char)) begin
            idle_mode = MODE_NUMBER;
            idle_acc  = {60'd0, in_char[3:0]};
        end else if (in_char == CHAR_QUOTE) begin
            idle_mode = MODE_STRING;
            idle_acc  = 64'd0;
        end else if (is_alpha_us(in_char)) begin
            idle_mode = MODE_IDENT;
            idle_acc  = {56'd0, in_char};
        end else if (is_operator(in_char)) begin
            idle_emit = 1'b1;
            idle_kind = KIND_OPERATOR;
        end else if (is_delim(in_char)) begin
            idle_emit = 1'b1;
            idle_kind = KIND_DELIM;
        end else begin
            idle_emit = 1'b1;
            idle_kind = KIND_UNDEF;
        end
    end

    // pending token and whether the byte then runs through idle handling
    always_comb begin
        pend_emit = 1'b0;
        pend_kind = KIND_NUMBER;
        use_idle  = 1'b0;
        unique case (mode_reg)
            MODE_NUMBER: begin
                pend_kind = KIND_NUMBER;
                pend_emit = !is_digit(in_char);
                use_idle  = pend_emit;
            end
            MODE_STRING: begin
                pend_kind = KIND_STRING;
                pend_emit = (in_char == CHAR_QUOTE) || (in_char == CHAR_NUL);
                use_idle  = (in_char == CHAR_NUL);
            end
            MODE_IDENT: begin
                pend_kind = KIND_IDENT;
                pend_emit = !(is_alpha_us(in_char) || is_digit(in_char));
                use_idle  = pend_emit;
            end
            MODE_IDLE: begin
                use_idle = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        if (accept) begin
            priority if (use_idle) begin
                mode_next = idle_mode;
                acc_next  = idle_acc;
            end else if (pend_emit) begin
                mode_next = MODE_IDLE;
            end else if (mode_reg == MODE_NUMBER) begin
                acc_next = acc_times10 + digit_ext;
            end else begin
                acc_next = acc_shift8;
            end
        end
    end

    // outputs
    always_comb begin
        push_entry.two    = pend_emit && use_idle && idle_emit;
        push_entry.kind1  = idle_kind;
        push_entry.char1  = in_char;
        if (pend_emit) begin
            push_entry.kind0  = pend_kind;
            push_entry.value0 = acc_reg;
        end else begin
            push_entry.kind0  = idle_kind;
            push_entry.value0 = {56'd0, in_char};
        end
        push_valid = accept && (pend_emit || (use_idle && idle_emit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 64'd0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

FILE: sv/sct_queue.sv
// Short FIFO of classified entries between the front and back ends.
// Depends on sct_pkg.
module sct_queue #(
    parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  sct_pkg::sct_entry_t push_entry,
    output logic                push_ready,
    output logic                pop_valid,
    output sct_pkg::sct_entry_t pop_entry,
    input  logic                pop
);
    import sct_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sct_entry_t    slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/sct_back.sv
// Back end: splits queue entries into tokens and holds the output register.
// Depends on sct_pkg.
module sct_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      entry_valid,
    input  sct_pkg::sct_entry_t       entry,
    output logic                      entry_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sct_pkg::kind_t            out_kind,
    output logic [63:0]               out_value,
    output logic                      out_last,
    output sct_pkg::sct_back_status_t status
);
    import sct_pkg::*;

    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [63:0] value_reg, value_next;
    logic        last_reg, last_next;
    logic        phase_reg, phase_next;
    logic        load;

    assign load = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        entry_pop  = 1'b0;
        if (load) begin
            priority if (phase_reg) begin
                valid_next = 1'b1;
                kind_next  = entry.kind1;
                value_next = {56'd0, entry.char1};
                last_next  = 1'b1;
                phase_next = 1'b0;
                entry_pop  = 1'b1;
            end else if (entry_valid) begin
                valid_next = 1'b1;
                kind_next  = entry.kind0;
                value_next = entry.value0;
                last_next  = !entry.two;
                phase_next = entry.two;
                entry_pop  = !entry.two;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign out_valid             = valid_reg;
    assign out_kind              = kind_reg;
    assign out_value             = value_reg;
    assign out_last              = last_reg;
    assign status.second_pending = phase_reg;

endmodule

FILE: sv/source_char_tokenizer_core.sv
// Source character tokenizer, top level: front end, entry queue, back end.
// Depends on sct_pkg, sct_front, sct_queue, sct_back.
//
// Streaming lexer. One source byte per request on the slave side (byte 0 ends
// the text); tokens leave on the master side with the kind in tuser, the
// 64-bit value in tdata and tlast on the final token a byte causes. The front
// end takes a byte every cycle while the queue has room; mode and accumulator
// update as each byte is taken (times ten as shift-and-add, times 256 as a
// shift). A byte that closes a pending number, identifier or unterminated
// string and is itself a token gives two tokens; the back end sends those
// one after the other from one queue entry. Sustained rate is one byte per
// cycle while tokens average at most one per cycle; the result port (one token
// per cycle) is the limit, and the QUEUE_DEPTH-entry queue absorbs bursts of
// double tokens and output stalls. Whitespace and bytes that extend a token
// produce nothing. The accumulator wraps modulo 2^64.
module source_char_tokenizer_core #(
    parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] token_value
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import sct_pkg::*;

    logic             push_valid, push_ready;
    sct_entry_t       push_entry;
    logic             q_valid, q_pop;
    sct_entry_t       q_entry;
    kind_t            out_kind;
    sct_back_status_t back_status;

    sct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .push_ready (push_ready),
        .in_ready   (s_tready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry),
        .pop        (q_pop)
    );

    sct_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_valid (q_valid),
        .entry       (q_entry),
        .entry_pop   (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_value   (m_tdata),
        .out_last    (m_tlast),
        .status      (back_status)
    );

    assign m_tuser = out_kind;

    // Head entry must stay queued while its second token waits.
    a_second_keeps_head: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.second_pending |-> q_valid)
        else $error("second token pending without a queued entry");

    // While the second token waits, the first is on the port and not last.
    a_second_behind_first: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.second_pending |-> (m_tvalid && !m_tlast))
        else $error("second token pending but first token not held");

    // End of text is always the final token of its byte.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_END)) |-> m_tlast)
        else $error("end token not marked last");

    // Only a closed number, string or identifier can precede another token.
    a_first_is_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |->
        ((m_tuser == KIND_NUMBER) || (m_tuser == KIND_STRING) || (m_tuser == KIND_IDENT)))
        else $error("non-final token of unexpected kind");

endmodule
